>>> rtl/ibea_pkg.sv
// ibea_pkg: widths, register indexes, edge mode codes and shared types
// for the image border extension addresser. No dependencies.
`timescale 1ns / 1ps

package ibea_pkg;

   // limits applied to the programmed sizes and pads
   localparam int MAX_DIM = 4096;
   localparam int MAX_PAD = 4096;

   localparam int REG_W  = 13;          // configuration register width
   localparam int IN_W   = 14;          // extended image coordinate
   localparam int OUT_W  = 12;          // source coordinate
   localparam int IDX_W  = 3;           // register index
   localparam int MODE_W = 2;
   localparam int EXT_W  = REG_W + 2;   // pad + size + pad
   localparam int DIFF_W = IN_W + 1;    // signed offset from the source origin
   localparam int PER_W  = REG_W + 1;   // fold period, up to twice the size

   localparam int REG_MAX = (2 ** REG_W) - 1;
   localparam int DIM_CAP = (MAX_DIM > REG_MAX) ? REG_MAX : ((MAX_DIM < 1) ? 1 : MAX_DIM);
   localparam int PAD_CAP = (MAX_PAD > REG_MAX) ? REG_MAX : MAX_PAD;

   localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [IDX_W-1:0] REG_PAD_LEFT   = 3'd2;
   localparam logic [IDX_W-1:0] REG_PAD_RIGHT  = 3'd3;
   localparam logic [IDX_W-1:0] REG_PAD_TOP    = 3'd4;
   localparam logic [IDX_W-1:0] REG_PAD_BOTTOM = 3'd5;
   localparam logic [IDX_W-1:0] REG_EDGE_MODE  = 3'd6;

   localparam logic [MODE_W-1:0] MODE_FILL     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLAMP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MIRROR   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd3;

   // one axis of an item on its way through the remainder pipeline
   typedef struct packed {
      logic             neg;      // offset below the source origin
      logic             in_span;  // offset within [0, size)
      logic [IN_W-1:0]  mag;      // offset, or -offset-1 when negative
      logic [PER_W-1:0] rem;      // partial remainder, later the folded position
   } axis_type;

   typedef struct packed {
      axis_type cx;
      axis_type cy;
      logic     fill;
      logic     oor;
   } item_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dc;
      logic signed [DIFF_W-1:0] dr;
      logic                     oor;
   } diff_type;

   // size register as used: zero reads as one, large values saturate
   function automatic logic [REG_W-1:0] eff_size(input logic [REG_W-1:0] v);
      logic [REG_W-1:0] r;
      if (v == '0) begin
         r = REG_W'(1);
      end else if (v > REG_W'(DIM_CAP)) begin
         r = REG_W'(DIM_CAP);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [REG_W-1:0] eff_pad(input logic [REG_W-1:0] v);
      logic [REG_W-1:0] r;
      if (v > REG_W'(PAD_CAP)) begin
         r = REG_W'(PAD_CAP);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

>>> rtl/image_border_extension_addresser.sv
// Throughput: one coordinate per cycle while rsp_ready is high and no register write is
// offered; the depth is set by the restoring remainder pipeline, one quotient bit per
// stage over the 14-bit offset magnitude.
// Reset (synchronous, active high) empties the pipeline and loads the register reset
// values: width 1, height 1, no padding, fixed fill mode. Uses ibea_pkg.
`timescale 1ns / 1ps

module image_border_extension_addresser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ibea_pkg::IN_W-1:0]  req_out_col,
   input  logic [ibea_pkg::IN_W-1:0]  req_out_row,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ibea_pkg::OUT_W-1:0] rsp_src_col,
   output logic [ibea_pkg::OUT_W-1:0] rsp_src_row,
   output logic                       rsp_use_fill,
   output logic                       rsp_out_of_range,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ibea_pkg::IDX_W-1:0] csr_index,
   input  logic [ibea_pkg::REG_W-1:0] csr_wdata
);
   import ibea_pkg::*;

   localparam int NDIV = IN_W;       // remainder steps, one per offset bit
   localparam int NST  = NDIV + 5;   // input, diff, prep, steps, unfold, output
   localparam int FIN  = NST - 1;

   // ---------------------------------------------------------------- registers
   logic [REG_W-1:0]  src_width_ff, src_height_ff;
   logic [REG_W-1:0]  pad_left_ff, pad_right_ff, pad_top_ff, pad_bottom_ff;
   logic [MODE_W-1:0] edge_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= REG_W'(1);
         src_height_ff <= REG_W'(1);
         pad_left_ff   <= '0;
         pad_right_ff  <= '0;
         pad_top_ff    <= '0;
         pad_bottom_ff <= '0;
         edge_mode_ff  <= MODE_FILL;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            REG_SRC_HEIGHT: src_height_ff <= csr_wdata;
            REG_PAD_LEFT:   pad_left_ff   <= csr_wdata;
            REG_PAD_RIGHT:  pad_right_ff  <= csr_wdata;
            REG_PAD_TOP:    pad_top_ff    <= csr_wdata;
            REG_PAD_BOTTOM: pad_bottom_ff <= csr_wdata;
            REG_EDGE_MODE:  edge_mode_ff  <= csr_wdata[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // effective sizes and derived bounds, registered from the configuration registers;
   // the first stage that reads them sees an item in the cycle after acceptance
   logic [REG_W-1:0] w_ff, h_ff, pl_ff, pt_ff;
   logic [EXT_W-1:0] ext_w_ff, ext_h_ff;
   logic [PER_W-1:0] per_w_ff, per_h_ff;

   always_ff @(posedge clock) begin
      w_ff     <= eff_size(src_width_ff);
      h_ff     <= eff_size(src_height_ff);
      pl_ff    <= eff_pad(pad_left_ff);
      pt_ff    <= eff_pad(pad_top_ff);
      ext_w_ff <= EXT_W'(eff_pad(pad_left_ff)) + EXT_W'(eff_size(src_width_ff))
                + EXT_W'(eff_pad(pad_right_ff));
      ext_h_ff <= EXT_W'(eff_pad(pad_top_ff)) + EXT_W'(eff_size(src_height_ff))
                + EXT_W'(eff_pad(pad_bottom_ff));
      per_w_ff <= (edge_mode_ff == MODE_MIRROR) ? {eff_size(src_width_ff), 1'b0}
                                                : {1'b0, eff_size(src_width_ff)};
      per_h_ff <= (edge_mode_ff == MODE_MIRROR) ? {eff_size(src_height_ff), 1'b0}
                                                : {1'b0, eff_size(src_height_ff)};
   end

   // ---------------------------------------------------------------- flow control
   // a stage loads when it is empty or the output moves; a stalled stage hands its
   // beat to an empty successor and goes empty, so bubbles close up without a chain
   logic [NST-1:0] vld_ff, vld_in, en;
   logic           adv;

   assign adv = ~vld_ff[FIN] | rsp_ready;

   always_comb begin
      for (int k = 0; k < NST; k++) begin
         en[k] = ~vld_ff[k] | adv;
      end
      vld_in[0] = en[0] ? (req_valid & ~csr_valid) : (vld_ff[0] & ~en[1]);
      for (int k = 1; k < FIN; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : (vld_ff[k] & ~en[k+1]);
      end
      vld_in[FIN] = en[FIN] ? vld_ff[FIN-1] : vld_ff[FIN];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // a register write and a request never land on the same edge
   assign req_ready = en[0] & ~csr_valid;

   // ---------------------------------------------------------------- input and offset
   logic [IN_W-1:0] col_ff, row_ff;
   diff_type        dif_ff, dif_in;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         col_ff <= req_out_col;
         row_ff <= req_out_row;
      end
   end

   always_comb begin
      dif_in.dc  = $signed({1'b0, col_ff}) - $signed(DIFF_W'(pl_ff));
      dif_in.dr  = $signed({1'b0, row_ff}) - $signed(DIFF_W'(pt_ff));
      dif_in.oor = (EXT_W'(col_ff) >= ext_w_ff) || (EXT_W'(row_ff) >= ext_h_ff);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         dif_ff <= dif_in;
      end
   end

   // ---------------------------------------------------------------- prep
   function automatic axis_type axis_prep(input logic signed [DIFF_W-1:0] d,
                                          input logic [REG_W-1:0] n);
      axis_type a;
      a.neg     = d[DIFF_W-1];
      a.mag     = d[DIFF_W-1] ? ~d[IN_W-1:0] : d[IN_W-1:0];
      a.in_span = ~d[DIFF_W-1] && (d[IN_W-1:0] < IN_W'(n));
      a.rem     = '0;
      return a;
   endfunction

   item_type itm_ff [NDIV+2];
   item_type prep_in;

   always_comb begin
      prep_in.cx   = axis_prep(dif_ff.dc, w_ff);
      prep_in.cy   = axis_prep(dif_ff.dr, h_ff);
      prep_in.oor  = dif_ff.oor;
      prep_in.fill = (edge_mode_ff == MODE_FILL)
                   && !(prep_in.cx.in_span && prep_in.cy.in_span);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         itm_ff[0] <= prep_in;
      end
   end

   // ---------------------------------------------------------------- remainder steps
   function automatic logic [PER_W-1:0] rem_step(input logic [PER_W-1:0] rem,
                                                 input logic b,
                                                 input logic [PER_W-1:0] p);
      logic [PER_W:0] t;
      t = {rem, b};
      if (t >= {1'b0, p}) begin
         t = t - {1'b0, p};
      end
      return t[PER_W-1:0];
   endfunction

   for (genvar j = 0; j < NDIV; j++) begin : g_div
      item_type step_in;

      always_comb begin
         step_in        = itm_ff[j];
         step_in.cx.rem = rem_step(itm_ff[j].cx.rem, itm_ff[j].cx.mag[NDIV-1-j], per_w_ff);
         step_in.cy.rem = rem_step(itm_ff[j].cy.rem, itm_ff[j].cy.mag[NDIV-1-j], per_h_ff);
      end

      always_ff @(posedge clock) begin
         if (en[3+j]) begin
            itm_ff[j+1] <= step_in;
         end
      end
   end

   // ---------------------------------------------------------------- unfold sign
   // a negative offset d was divided as -d-1, so its positive remainder is p-1-r
   item_type unf_in;

   always_comb begin
      unf_in = itm_ff[NDIV];
      if (itm_ff[NDIV].cx.neg) begin
         unf_in.cx.rem = per_w_ff - PER_W'(1) - itm_ff[NDIV].cx.rem;
      end
      if (itm_ff[NDIV].cy.neg) begin
         unf_in.cy.rem = per_h_ff - PER_W'(1) - itm_ff[NDIV].cy.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NDIV+3]) begin
         itm_ff[NDIV+1] <= unf_in;
      end
   end

   // ---------------------------------------------------------------- select and output
   function automatic logic [OUT_W-1:0] axis_out(input axis_type a,
                                                 input logic [REG_W-1:0] n,
                                                 input logic [PER_W-1:0] p,
                                                 input logic [MODE_W-1:0] mode);
      logic [PER_W-1:0] fold;
      logic [REG_W-1:0] last;
      logic [OUT_W-1:0] r;
      fold = (a.rem >= {1'b0, n}) ? (p - PER_W'(1) - a.rem) : a.rem;
      last = n - REG_W'(1);
      if (a.in_span) begin
         r = a.mag[OUT_W-1:0];
      end else begin
         case (mode)
            MODE_CLAMP:    r = a.neg ? '0 : last[OUT_W-1:0];
            MODE_MIRROR:   r = fold[OUT_W-1:0];
            MODE_PERIODIC: r = a.rem[OUT_W-1:0];
            default:       r = '0;
         endcase
      end
      return r;
   endfunction

   logic [OUT_W-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic             use_fill_ff, use_fill_in, oor_ff, oor_in;

   always_comb begin
      oor_in      = itm_ff[NDIV+1].oor;
      use_fill_in = ~itm_ff[NDIV+1].oor & itm_ff[NDIV+1].fill;
      if (itm_ff[NDIV+1].oor || itm_ff[NDIV+1].fill) begin
         src_col_in = '0;
         src_row_in = '0;
      end else begin
         src_col_in = axis_out(itm_ff[NDIV+1].cx, w_ff, per_w_ff, edge_mode_ff);
         src_row_in = axis_out(itm_ff[NDIV+1].cy, h_ff, per_h_ff, edge_mode_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[FIN]) begin
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         use_fill_ff <= use_fill_in;
         oor_ff      <= oor_in;
      end
   end

   assign rsp_valid        = vld_ff[FIN];
   assign rsp_src_col      = src_col_ff;
   assign rsp_src_row      = src_row_ff;
   assign rsp_use_fill     = use_fill_ff;
   assign rsp_out_of_range = oor_ff;

   // ---------------------------------------------------------------- assertions
   // request beats are held off while a register write is offered
   a_cfg_order: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> !req_ready)
      else $error("request accepted together with a register write");

   // out of range and fill are exclusive in a response beat
   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_use_fill && rsp_out_of_range))
      else $error("fill and out of range both set");

   // flagged beats carry zero coordinates
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_use_fill || rsp_out_of_range))
         |-> (rsp_src_col == '0 && rsp_src_row == '0))
      else $error("flagged beat with nonzero coordinates");

   // a held response beat keeps its stage occupied and its data
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[FIN] && !rsp_ready) |=> (vld_ff[FIN] && $stable(src_col_ff)
                                       && $stable(src_row_ff)))
      else $error("stalled response beat lost or changed");

endmodule

>>> test/tb.sv
// tb: self-checking bench for image_border_extension_addresser. It predicts the source
// coordinate, fill and range flags of every coordinate beat and checks each response.
// Depends on ibea_pkg and the addresser RTL.
`timescale 1ns / 1ps

module tb;
   import ibea_pkg::*;

   localparam logic [IDX_W-1:0] REG_UNKNOWN = 3'd7;
   localparam int LATENCY_SLACK = 30;

   typedef struct packed {
      logic [OUT_W-1:0] src_col;
      logic [OUT_W-1:0] src_row;
      logic             use_fill;
      logic             out_of_range;
   } src_lookup_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [IN_W-1:0]   req_out_col = '0;
   logic [IN_W-1:0]   req_out_row = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [OUT_W-1:0]  rsp_src_col;
   logic [OUT_W-1:0]  rsp_src_row;
   logic              rsp_use_fill;
   logic              rsp_out_of_range;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [REG_W-1:0]  csr_wdata = '0;

   // programmed register values as the block should hold them
   logic [REG_W-1:0]  width_reg;
   logic [REG_W-1:0]  height_reg;
   logic [REG_W-1:0]  pad_left_reg;
   logic [REG_W-1:0]  pad_right_reg;
   logic [REG_W-1:0]  pad_top_reg;
   logic [REG_W-1:0]  pad_bottom_reg;
   logic [MODE_W-1:0] mode_reg;

   src_lookup_type pending_lookups[$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   image_border_extension_addresser dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_out_col(req_out_col),
      .req_out_row(req_out_row),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_src_col(rsp_src_col),
      .rsp_src_row(rsp_src_row),
      .rsp_use_fill(rsp_use_fill),
      .rsp_out_of_range(rsp_out_of_range),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: timeout with %0d lookups pending", pending_lookups.size());
      $display("tb: errors");
      $finish;
   end

   function automatic int size_limit(input logic [REG_W-1:0] v);
      int r;
      r = int'(v);
      if (r == 0) begin
         r = 1;
      end else if (r > MAX_DIM) begin
         r = MAX_DIM;
      end
      return r;
   endfunction

   function automatic int pad_limit(input logic [REG_W-1:0] v);
      return (int'(v) > MAX_PAD) ? MAX_PAD : int'(v);
   endfunction

   function automatic int ext_cols();
      return pad_limit(pad_left_reg) + size_limit(width_reg) + pad_limit(pad_right_reg);
   endfunction

   function automatic int ext_rows();
      return pad_limit(pad_top_reg) + size_limit(height_reg) + pad_limit(pad_bottom_reg);
   endfunction

   function automatic int pos_mod(input int d, input int p);
      int m;
      m = d % p;
      if (m < 0) begin
         m = m + p;
      end
      return m;
   endfunction

   // offset from the source origin folded back into [0, n)
   function automatic int fold_axis(input int d, input int n);
      int k;
      if (d >= 0 && d < n) begin
         return d;
      end
      case (mode_reg)
         MODE_CLAMP: begin
            return (d < 0) ? 0 : n - 1;
         end
         MODE_MIRROR: begin
            k = pos_mod(d, 2 * n);
            return (k >= n) ? 2 * n - 1 - k : k;
         end
         default: begin
            return pos_mod(d, n);
         end
      endcase
   endfunction

   function automatic src_lookup_type predict_source(input logic [IN_W-1:0] col,
                                                     input logic [IN_W-1:0] row);
      src_lookup_type r;
      int          w;
      int          h;
      int          dc;
      int          dr;
      bit          outside;
      r = '0;
      w = size_limit(width_reg);
      h = size_limit(height_reg);
      if (int'(col) >= ext_cols() || int'(row) >= ext_rows()) begin
         r.out_of_range = 1'b1;
      end else begin
         dc = int'(col) - pad_limit(pad_left_reg);
         dr = int'(row) - pad_limit(pad_top_reg);
         outside = dc < 0 || dc >= w || dr < 0 || dr >= h;
         if (mode_reg == MODE_FILL && outside) begin
            r.use_fill = 1'b1;
         end else begin
            r.src_col = OUT_W'(fold_axis(dc, w));
            r.src_row = OUT_W'(fold_axis(dr, h));
         end
      end
      return r;
   endfunction

   // response side: random back-pressure and the check of every accepted beat
   always @(posedge clock) begin
      src_lookup_type want;
      src_lookup_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_src_col, rsp_src_row, rsp_use_fill, rsp_out_of_range};
         if (pending_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("tb: %0t response beat with no lookup pending", $realtime);
            end
         end else begin
            want = pending_lookups.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("tb: %0t mismatch col exp %0d got %0d, row exp %0d got %0d",
                           $realtime, want.src_col, got.src_col, want.src_row,
                           got.src_row);
                  $display("tb:    fill exp %0b got %0b, out_of_range exp %0b got %0b",
                           want.use_fill, got.use_fill, want.out_of_range,
                           got.out_of_range);
               end
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_coord(input logic [IN_W-1:0] col, input logic [IN_W-1:0] row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_out_col <= col;
      req_out_row <= row;
      do @(posedge clock); while (!req_ready);
      pending_lookups.push_back(predict_source(col, row));
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SRC_WIDTH:  width_reg = data;
         REG_SRC_HEIGHT: height_reg = data;
         REG_PAD_LEFT:   pad_left_reg = data;
         REG_PAD_RIGHT:  pad_right_reg = data;
         REG_PAD_TOP:    pad_top_reg = data;
         REG_PAD_BOTTOM: pad_bottom_reg = data;
         REG_EDGE_MODE:  mode_reg = data[MODE_W-1:0];
         default: ;
      endcase
   endtask

   // stop the coordinate stream, let the pipe drain, then program all registers
   task automatic configure(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h,
                            input logic [REG_W-1:0] pl, input logic [REG_W-1:0] pr,
                            input logic [REG_W-1:0] pt, input logic [REG_W-1:0] pb,
                            input logic [REG_W-1:0] mode_word);
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      write_reg(REG_SRC_WIDTH, w);
      write_reg(REG_SRC_HEIGHT, h);
      write_reg(REG_PAD_LEFT, pl);
      write_reg(REG_PAD_RIGHT, pr);
      write_reg(REG_PAD_TOP, pt);
      write_reg(REG_PAD_BOTTOM, pb);
      write_reg(REG_EDGE_MODE, mode_word);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_values();
      send_coord(14'd0, 14'd0);
      send_coord(14'd1, 14'd0);
      send_coord(14'd0, 14'd1);
      send_coord(14'h3fff, 14'h3fff);
   endtask

   task automatic test_edge_modes();
      logic [MODE_W-1:0] m;
      for (int i = 0; i < 4; i++) begin
         m = MODE_W'(i);
         configure(13'd5, 13'd3, 13'd2, 13'd3, 13'd1, 13'd2, REG_W'(m));
         send_coord(14'd0, 14'd0);
         send_coord(14'(ext_cols() - 1), 14'(ext_rows() - 1));
         send_coord(14'd2, 14'd1);
         send_coord(14'(ext_cols()), 14'd0);
      end
   endtask

   // zero and oversized sizes, oversized pads, high mode bits, unknown index
   task automatic test_saturation();
      configure(13'd0, 13'h1fff, 13'h1fff, 13'h1fff, 13'h1fff, 13'h1fff,
                {11'h7ff, MODE_MIRROR});
      write_reg(REG_UNKNOWN, 13'h0aaa);
      csr_valid <= 1'b0;
      send_coord(14'd0, 14'd0);
      send_coord(14'd4096, 14'd8191);
      send_coord(14'd12288, 14'd12287);
      send_coord(14'h3fff, 14'd100);
      configure(13'h1fff, 13'd0, 13'd0, 13'd0, 13'd4096, 13'd4096, REG_W'(MODE_PERIODIC));
      send_coord(14'd4095, 14'd8192);
      send_coord(14'd4096, 14'd0);
   endtask

   function automatic logic [REG_W-1:0] pick_size();
      case ($urandom_range(9))
         0: return '0;
         1: return 13'd1;
         2: return 13'd4096;
         3: return 13'($urandom_range(4097, 8191));
         4: return 13'($urandom_range(1, 4096));
         default: return 13'($urandom_range(2, 24));
      endcase
   endfunction

   function automatic logic [REG_W-1:0] pick_pad();
      case ($urandom_range(9))
         0, 1: return '0;
         2: return 13'd4096;
         3: return 13'($urandom_range(4097, 8191));
         4: return 13'($urandom_range(0, 4096));
         default: return 13'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic logic [IN_W-1:0] pick_coord(input int ext);
      case ($urandom_range(19))
         0, 1, 2: return IN_W'($urandom);
         3, 4: return IN_W'(ext + $urandom_range(0, 3) - 2);
         default: return IN_W'($urandom_range(0, ext - 1));
      endcase
   endfunction

   task automatic test_random_configs(input int n_configs, input int per_config);
      for (int c = 0; c < n_configs; c++) begin
         configure(pick_size(), pick_size(), pick_pad(), pick_pad(), pick_pad(), pick_pad(),
                   13'($urandom));
         for (int i = 0; i < per_config; i++) begin
            send_coord(pick_coord(ext_cols()), pick_coord(ext_rows()));
         end
      end
   endtask

   initial begin
      width_reg = 13'd1;
      height_reg = 13'd1;
      pad_left_reg = '0;
      pad_right_reg = '0;
      pad_top_reg = '0;
      pad_bottom_reg = '0;
      mode_reg = MODE_FILL;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 6;
      recv_idle_pct = 66;
      test_reset_values();
      test_edge_modes();
      test_saturation();
      test_random_configs(5, 50);

      send_idle_pct = 66;
      recv_idle_pct = 6;
      test_random_configs(5, 50);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_configs(5, 50);

      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
